[hw/rtl/tba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_pkg
// Shared codes for the texture bilinear address unit: register indexes,
// addressing modes and filter modes.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_TEX_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEX_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_U_MODE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_V_MODE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 3'd4;

    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;

    localparam logic FILTER_POINT    = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    localparam int COORD_W  = 24;
    localparam int INDEX_W  = 24;
    localparam int WEIGHT_W = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

endpackage

[hw/rtl/tba_mod_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_mod_stage
// One restoring remainder step for both axes, with its own register and
// handshake; a chain of these forms the pipelined modulo unit.
// ----------------------------------------------------------------------------
module tba_mod_stage #(
    parameter int MW     = 16,
    parameter int DW     = 14,
    parameter int BIT    = 15,
    parameter int SIDE_W = 42
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MW-1:0]     in_mag_u,
    input  logic [MW-1:0]     in_mag_v,
    input  logic [DW-1:0]     in_rem_u,
    input  logic [DW-1:0]     in_rem_v,
    input  logic              in_neg_u,
    input  logic              in_neg_v,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DW-1:0]     div_u,
    input  logic [DW-1:0]     div_v,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MW-1:0]     out_mag_u,
    output logic [MW-1:0]     out_mag_v,
    output logic [DW-1:0]     out_rem_u,
    output logic [DW-1:0]     out_rem_v,
    output logic              out_neg_u,
    output logic              out_neg_v,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg;
    logic [MW-1:0]     mag_u_reg, mag_v_reg;
    logic [DW-1:0]     rem_u_reg, rem_v_reg;
    logic [DW-1:0]     rem_u_next, rem_v_next;
    logic              neg_u_reg, neg_v_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DW:0]       shift_u, shift_v;

    assign in_ready = !vld_reg || out_ready;

    // bring down one dividend bit, subtract where it fits
    always_comb
    begin
        shift_u = {in_rem_u, in_mag_u[BIT]};
        shift_v = {in_rem_v, in_mag_v[BIT]};
        if (shift_u >= {1'b0, div_u})
            rem_u_next = DW'(shift_u - {1'b0, div_u});
        else
            rem_u_next = DW'(shift_u);
        if (shift_v >= {1'b0, div_v})
            rem_v_next = DW'(shift_v - {1'b0, div_v});
        else
            rem_v_next = DW'(shift_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            mag_u_reg <= in_mag_u;
            mag_v_reg <= in_mag_v;
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            neg_u_reg <= in_neg_u;
            neg_v_reg <= in_neg_v;
            side_reg  <= in_side;
        end
    end

    assign out_valid = vld_reg;
    assign out_mag_u = mag_u_reg;
    assign out_mag_v = mag_v_reg;
    assign out_rem_u = rem_u_reg;
    assign out_rem_v = rem_v_reg;
    assign out_neg_u = neg_u_reg;
    assign out_neg_v = neg_v_reg;
    assign out_side  = side_reg;

endmodule

[hw/rtl/texture_bilinear_address_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_bilinear_address_unit
// Turns a signed fixed-point (u, v) coordinate into four texel indices and
// four bilinear weights under clamp, repeat or mirrored-repeat addressing.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one coordinate pair per transfer; output
//   stream m_axis carries one result per input, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   unit is empty; writes take effect at once.
//   The pipeline is the chain of one-bit remainder steps of the
//   floor-modulo unit, plus one input stage and four stages for
//   addressing, multiply and sum. Unless the receiver stalls,
//   throughput is one transfer per cycle: every stage holds its own valid
//   bit and loads whenever it is empty or its successor moves, so bubbles
//   are squeezed out and the input keeps flowing while a result waits.
//   When the receiver stalls, the pipeline fills up and s_axis_tready
//   falls only once every stage holds an item; nothing is lost or repeated.
//   Reset clears all valid bits and sets the registers to width 1,
//   height 1, clamp addressing and point sampling.
// ----------------------------------------------------------------------------
module texture_bilinear_address_unit #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [23:0] u_coord, [47:24] v_coord
    input  logic [47:0]                      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [23:0] index_top_left, [47:24] index_top_right,
    // [71:48] index_bottom_left, [95:72] index_bottom_right,
    // [112:96] weight_top_left, [129:113] weight_top_right,
    // [146:130] weight_bottom_left, [163:147] weight_bottom_right, rest zero
    output logic [167:0]                     m_axis_tdata
);

    import tba_pkg::*;

    localparam int IW     = COORD_W - FRAC_BITS;          // integer texel bits
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DW     = DIM_W + 1;                    // holds 2 * size
    localparam int CW     = (IW > DIM_W) ? IW : DIM_W;
    localparam int PW     = 2 * DIM_W;
    localparam int SW     = (PW + 1 > INDEX_W) ? PW + 1 : INDEX_W;
    localparam int SIDE_W = 2 * FRAC_BITS + 2 * DIM_W;
    localparam int FSHIFT = 16 - FRAC_BITS;

    // ---------------------------------------------------------------- config
    logic [CFG_DATA_W-1:0] tex_width_reg, tex_height_reg;
    logic [1:0]            u_mode_reg, v_mode_reg;
    logic                  filter_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg   <= 13'd1;
            tex_height_reg  <= 13'd1;
            u_mode_reg      <= MODE_CLAMP;
            v_mode_reg      <= MODE_CLAMP;
            filter_mode_reg <= FILTER_POINT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:   tex_width_reg   <= cfg_data;
                REG_TEX_HEIGHT:  tex_height_reg  <= cfg_data;
                REG_U_MODE:      u_mode_reg      <= cfg_data[1:0];
                REG_V_MODE:      v_mode_reg      <= cfg_data[1:0];
                REG_FILTER_MODE: filter_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, oversize acts as MAX_DIM.
    // The user must change registers only while the pipeline is empty; the
    // block itself does not enforce it, and every stage reads these directly.
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DW-1:0]    div_u, div_v;

    always_comb
    begin
        if (tex_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(tex_width_reg) > 32'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = DIM_W'(tex_width_reg);
        if (tex_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(tex_height_reg) > 32'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = DIM_W'(tex_height_reg);
        // mirror folds over a period of twice the size
        div_u = (u_mode_reg == MODE_MIRROR) ? {w_eff, 1'b0} : DW'(w_eff);
        div_v = (v_mode_reg == MODE_MIRROR) ? {h_eff, 1'b0} : DW'(h_eff);
    end

    // ---------------------------------------------------- ready chain
    logic s0_rdy, f_rdy, g_rdy, h_rdy, o_rdy;
    logic s0_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg, o_vld_reg;

    logic              c_vld   [0:IW];
    logic              c_rdy   [0:IW];
    logic [IW-1:0]     c_mag_u [0:IW];
    logic [IW-1:0]     c_mag_v [0:IW];
    logic [DW-1:0]     c_rem_u [0:IW];
    logic [DW-1:0]     c_rem_v [0:IW];
    logic              c_neg_u [0:IW];
    logic              c_neg_v [0:IW];
    logic [SIDE_W-1:0] c_side  [0:IW];

    assign o_rdy    = !o_vld_reg || m_axis_tready;
    assign h_rdy    = !h_vld_reg || o_rdy;
    assign g_rdy    = !g_vld_reg || h_rdy;
    assign f_rdy    = !f_vld_reg || g_rdy;
    assign c_rdy[IW] = f_rdy;
    assign s0_rdy   = !s0_vld_reg || c_rdy[0];
    assign s_axis_tready = s0_rdy;

    // ------------------------------------------------ stage 0: split, clamp
    logic [IW-1:0]        ip_u, ip_v, mag_u, mag_v;
    logic [FRAC_BITS-1:0] fr_u, fr_v;
    logic [DIM_W-1:0]     cl_u, cl_v;

    always_comb
    begin
        // floor of the coordinate is an arithmetic shift
        ip_u  = s_axis_tdata[COORD_W-1:FRAC_BITS];
        ip_v  = s_axis_tdata[COORD_W+COORD_W-1:COORD_W+FRAC_BITS];
        fr_u  = s_axis_tdata[FRAC_BITS-1:0];
        fr_v  = s_axis_tdata[COORD_W+FRAC_BITS-1:COORD_W];
        mag_u = ip_u[IW-1] ? IW'(-ip_u) : ip_u;
        mag_v = ip_v[IW-1] ? IW'(-ip_v) : ip_v;
        if (ip_u[IW-1])
            cl_u = '0;
        else if (CW'(mag_u) >= CW'(w_eff))
            cl_u = w_eff - DIM_W'(1);
        else
            cl_u = DIM_W'(mag_u);
        if (ip_v[IW-1])
            cl_v = '0;
        else if (CW'(mag_v) >= CW'(h_eff))
            cl_v = h_eff - DIM_W'(1);
        else
            cl_v = DIM_W'(mag_v);
    end

    logic [IW-1:0]     s0_mag_u_reg, s0_mag_v_reg;
    logic              s0_neg_u_reg, s0_neg_v_reg;
    logic [SIDE_W-1:0] s0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (s0_rdy)
            s0_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_rdy)
        begin
            s0_mag_u_reg <= mag_u;
            s0_mag_v_reg <= mag_v;
            s0_neg_u_reg <= ip_u[IW-1];
            s0_neg_v_reg <= ip_v[IW-1];
            s0_side_reg  <= {fr_v, fr_u, cl_v, cl_u};
        end
    end

    assign c_vld[0]   = s0_vld_reg;
    assign c_mag_u[0] = s0_mag_u_reg;
    assign c_mag_v[0] = s0_mag_v_reg;
    assign c_rem_u[0] = '0;
    assign c_rem_v[0] = '0;
    assign c_neg_u[0] = s0_neg_u_reg;
    assign c_neg_v[0] = s0_neg_v_reg;
    assign c_side[0]  = s0_side_reg;

    // ------------------------------------- remainder chain, MSB first
    for (genvar k = 0; k < IW; k++)
    begin : g_mod
        tba_mod_stage #(
            .MW     (IW),
            .DW     (DW),
            .BIT    (IW - 1 - k),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_vld[k]),
            .in_ready  (c_rdy[k]),
            .in_mag_u  (c_mag_u[k]),
            .in_mag_v  (c_mag_v[k]),
            .in_rem_u  (c_rem_u[k]),
            .in_rem_v  (c_rem_v[k]),
            .in_neg_u  (c_neg_u[k]),
            .in_neg_v  (c_neg_v[k]),
            .in_side   (c_side[k]),
            .div_u     (div_u),
            .div_v     (div_v),
            .out_valid (c_vld[k+1]),
            .out_ready (c_rdy[k+1]),
            .out_mag_u (c_mag_u[k+1]),
            .out_mag_v (c_mag_v[k+1]),
            .out_rem_u (c_rem_u[k+1]),
            .out_rem_v (c_rem_v[k+1]),
            .out_neg_u (c_neg_u[k+1]),
            .out_neg_v (c_neg_v[k+1]),
            .out_side  (c_side[k+1])
        );
    end

    // ------------------------------- stage F: remainder to floor modulo
    logic [DW-1:0]     fm_u, fm_v;
    logic [DW-1:0]     f_fm_u_reg, f_fm_v_reg;
    logic [SIDE_W-1:0] f_side_reg;

    always_comb
    begin
        // a negative value with a non-zero remainder wraps up from the divisor
        if (c_neg_u[IW] && (c_rem_u[IW] != '0))
            fm_u = div_u - c_rem_u[IW];
        else
            fm_u = c_rem_u[IW];
        if (c_neg_v[IW] && (c_rem_v[IW] != '0))
            fm_v = div_v - c_rem_v[IW];
        else
            fm_v = c_rem_v[IW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (f_rdy)
            f_vld_reg <= c_vld[IW];
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy)
        begin
            f_fm_u_reg <= fm_u;
            f_fm_v_reg <= fm_v;
            f_side_reg <= c_side[IW];
        end
    end

    // ------------------------------ stage G: addressing and neighbours
    logic [DIM_W-1:0]     f_cl_u, f_cl_v;
    logic [FRAC_BITS-1:0] f_fr_u, f_fr_v;
    logic [DIM_W-1:0]     u0, v0, u1, v1;

    assign {f_fr_v, f_fr_u, f_cl_v, f_cl_u} = f_side_reg;

    always_comb
    begin
        case (u_mode_reg)
            MODE_REPEAT: u0 = DIM_W'(f_fm_u_reg);
            MODE_MIRROR:
                if (f_fm_u_reg < DW'(w_eff))
                    u0 = DIM_W'(f_fm_u_reg);
                else
                    u0 = DIM_W'(div_u - DW'(1) - f_fm_u_reg);
            default:     u0 = f_cl_u;
        endcase
        case (v_mode_reg)
            MODE_REPEAT: v0 = DIM_W'(f_fm_v_reg);
            MODE_MIRROR:
                if (f_fm_v_reg < DW'(h_eff))
                    v0 = DIM_W'(f_fm_v_reg);
                else
                    v0 = DIM_W'(div_v - DW'(1) - f_fm_v_reg);
            default:     v0 = f_cl_v;
        endcase
        // neighbour beyond the edge takes the edge texel
        u1 = (DW'(u0) + DW'(1) < DW'(w_eff)) ? u0 + DIM_W'(1) : u0;
        v1 = (DW'(v0) + DW'(1) < DW'(h_eff)) ? v0 + DIM_W'(1) : v0;
    end

    logic [DIM_W-1:0]     g_u0_reg, g_u1_reg, g_v0_reg, g_v1_reg;
    logic [FRAC_BITS-1:0] g_fr_u_reg, g_fr_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (g_rdy)
            g_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (g_rdy)
        begin
            g_u0_reg   <= u0;
            g_u1_reg   <= u1;
            g_v0_reg   <= v0;
            g_v1_reg   <= v1;
            g_fr_u_reg <= f_fr_u;
            g_fr_v_reg <= f_fr_v;
        end
    end

    // --------------------------------- stage H: row products, weights
    logic [WEIGHT_W-1:0] fx, fy, gx, gy;
    logic [2*WEIGHT_W-1:0] p_tl, p_tr, p_bl, p_br;
    logic [PW-1:0]       row0, row1;

    always_comb
    begin
        fx   = WEIGHT_W'(g_fr_u_reg) << FSHIFT;
        fy   = WEIGHT_W'(g_fr_v_reg) << FSHIFT;
        gx   = WEIGHT_ONE - fx;
        gy   = WEIGHT_ONE - fy;
        p_tl = (2*WEIGHT_W)'(gx) * (2*WEIGHT_W)'(gy);
        p_tr = (2*WEIGHT_W)'(fx) * (2*WEIGHT_W)'(gy);
        p_bl = (2*WEIGHT_W)'(gx) * (2*WEIGHT_W)'(fy);
        p_br = (2*WEIGHT_W)'(fx) * (2*WEIGHT_W)'(fy);
        row0 = PW'(g_v0_reg) * PW'(w_eff);
        row1 = PW'(g_v1_reg) * PW'(w_eff);
    end

    logic [PW-1:0]       h_row0_reg, h_row1_reg;
    logic [DIM_W-1:0]    h_u0_reg, h_u1_reg;
    logic [WEIGHT_W-1:0] h_w_tl_reg, h_w_tr_reg, h_w_bl_reg, h_w_br_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (h_rdy)
            h_vld_reg <= g_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (h_rdy)
        begin
            h_row0_reg <= row0;
            h_row1_reg <= row1;
            h_u0_reg   <= g_u0_reg;
            h_u1_reg   <= g_u1_reg;
            h_w_tl_reg <= p_tl[2*WEIGHT_W-2:16];
            h_w_tr_reg <= p_tr[2*WEIGHT_W-2:16];
            h_w_bl_reg <= p_bl[2*WEIGHT_W-2:16];
            h_w_br_reg <= p_br[2*WEIGHT_W-2:16];
        end
    end

    // ------------------------------ stage I: index sums, output register
    logic [SW-1:0]       s_tl, s_tr, s_bl, s_br;
    logic [INDEX_W-1:0]  i_tl, i_tr, i_bl, i_br;
    logic [WEIGHT_W-1:0] w_tl, w_tr, w_bl, w_br;

    always_comb
    begin
        s_tl = SW'(h_row0_reg) + SW'(h_u0_reg);
        s_tr = SW'(h_row0_reg) + SW'(h_u1_reg);
        s_bl = SW'(h_row1_reg) + SW'(h_u0_reg);
        s_br = SW'(h_row1_reg) + SW'(h_u1_reg);
        i_tl = s_tl[INDEX_W-1:0];
        if (filter_mode_reg == FILTER_POINT)
        begin
            // point sampling: base texel everywhere, all weight on it
            i_tr = i_tl;
            i_bl = i_tl;
            i_br = i_tl;
            w_tl = WEIGHT_ONE;
            w_tr = '0;
            w_bl = '0;
            w_br = '0;
        end
        else
        begin
            i_tr = s_tr[INDEX_W-1:0];
            i_bl = s_bl[INDEX_W-1:0];
            i_br = s_br[INDEX_W-1:0];
            w_tl = h_w_tl_reg;
            w_tr = h_w_tr_reg;
            w_bl = h_w_bl_reg;
            w_br = h_w_br_reg;
        end
    end

    logic [167:0] o_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (o_rdy)
            o_vld_reg <= h_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy)
            o_data_reg <= {4'b0, w_br, w_bl, w_tr, w_tl, i_br, i_bl, i_tr, i_tl};
    end

    assign m_axis_tvalid = o_vld_reg;
    assign m_axis_tdata  = o_data_reg;

`ifndef SYNTH
    // input backs off only when every stage is full and the sink stalls
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output not blocked");

    // point sampling puts all weight on the base texel
    a_point_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (filter_mode_reg == FILTER_POINT)) |->
        ((m_axis_tdata[112:96] == WEIGHT_ONE) && (m_axis_tdata[163:113] == '0)))
        else $error("point mode weights wrong");

    // bilinear weights sum to one at up to eight fraction bits
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (filter_mode_reg == FILTER_BILINEAR) && (FRAC_BITS <= 8)) |->
        ((19'(m_axis_tdata[112:96]) + 19'(m_axis_tdata[129:113])
          + 19'(m_axis_tdata[146:130]) + 19'(m_axis_tdata[163:147])) == 19'd65536))
        else $error("bilinear weights do not sum to one");

    // a stalled output holds its data
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
`endif

endmodule
